// File: src/cvl_pkg.sv
// ----------------------------------------------------------------------------
// cvl_pkg: shared types and microcode for the compacting value list
// Holds the transfer payloads, the status codes, the control word layout and
// the microprogram that drives the list datapath.
// ----------------------------------------------------------------------------
package cvl_pkg;

  // Command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] count;
  } out_item_t;

  // Control word fields
  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND,
    WR_SHIFT
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DELETE,
    COND_FULL,
    COND_EMPTY,
    COND_END,
    COND_MISMATCH
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the microprogram
  localparam step_t STEP_FETCH     = 4'd0;
  localparam step_t STEP_DISPATCH  = 4'd1;
  localparam step_t STEP_APP_CHK   = 4'd2;
  localparam step_t STEP_APP_WR    = 4'd3;
  localparam step_t STEP_DEL_CHK   = 4'd4;
  localparam step_t STEP_SRCH_RD   = 4'd5;
  localparam step_t STEP_SRCH_CMP  = 4'd6;
  localparam step_t STEP_SHIFT_RD  = 4'd7;
  localparam step_t STEP_SHIFT_WR  = 4'd8;
  localparam step_t STEP_DEL_DONE  = 4'd9;
  localparam step_t STEP_RES_FULL  = 4'd10;
  localparam step_t STEP_RES_EMPTY = 4'd11;
  localparam step_t STEP_RES_MISS  = 4'd12;

  typedef struct packed {
    idx_op_t    idx_op;
    wr_op_t     wr_op;
    cnt_op_t    cnt_op;
    logic       emit;
    logic [1:0] status;
    cond_t      cond;
    step_t      target;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic is_delete;
    logic full;
    logic empty;
    logic at_end;
    logic match;
    logic out_busy;
  } flags_t;

  localparam ucode_t UCODE_NOP = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                                   COND_NEXT, STEP_FETCH};

  // Microprogram ROM
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    w = UCODE_NOP;
    case (step)
      STEP_FETCH:     w = '{IDX_ZERO, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_NO_INPUT, STEP_FETCH};
      STEP_DISPATCH:  w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_DELETE, STEP_DEL_CHK};
      STEP_APP_CHK:   w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_FULL, STEP_RES_FULL};
      STEP_APP_WR:    w = '{IDX_HOLD, WR_APPEND, CNT_INC, 1'b1, ST_DONE,
                            COND_ALWAYS, STEP_FETCH};
      STEP_DEL_CHK:   w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_EMPTY, STEP_RES_EMPTY};
      STEP_SRCH_RD:   w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_END, STEP_RES_MISS};
      // index always advances: on a match it then points at the first entry to move
      STEP_SRCH_CMP:  w = '{IDX_INC, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_MISMATCH, STEP_SRCH_RD};
      STEP_SHIFT_RD:  w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_END, STEP_DEL_DONE};
      STEP_SHIFT_WR:  w = '{IDX_INC, WR_SHIFT, CNT_HOLD, 1'b0, ST_DONE,
                            COND_ALWAYS, STEP_SHIFT_RD};
      STEP_DEL_DONE:  w = '{IDX_HOLD, WR_NONE, CNT_DEC, 1'b1, ST_DONE,
                            COND_ALWAYS, STEP_FETCH};
      STEP_RES_FULL:  w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b1, ST_FULL,
                            COND_ALWAYS, STEP_FETCH};
      STEP_RES_EMPTY: w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b1, ST_EMPTY,
                            COND_ALWAYS, STEP_FETCH};
      STEP_RES_MISS:  w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b1, ST_NOT_FOUND,
                            COND_ALWAYS, STEP_FETCH};
      default:        w = '{IDX_HOLD, WR_NONE, CNT_HOLD, 1'b0, ST_DONE,
                            COND_ALWAYS, STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: src/compacting_value_list.sv
// Append passes the fetch, dispatch, check and write steps; a delete runs a search
// loop over the entries up to the match, then a shift loop over the entries that
// follow it, each loop taking one entry per pass of its read and compare or write step.
// One item in flight; the next input can be taken from the cycle after a result is loaded.
// Reset clears the sequencer, the entry count and the result valid; the store is
// not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
// compacting_value_list: ordered list with append and delete-by-value
// A microcoded sequencer drives a datapath holding the list store, the entry
// count and a registered result.
// ----------------------------------------------------------------------------
module compacting_value_list
  import cvl_pkg::*;
#(
  parameter int CAPACITY = 128
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ucode_t ctrl;
  flags_t flags;
  logic   idle;
  logic   in_fire;

  // Take a new item only at the fetch step
  assign in_stall = !idle;
  assign in_fire  = in_valid && idle;

  cvl_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  cvl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .out_stall (out_stall),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: src/cvl_sequencer.sv
// ----------------------------------------------------------------------------
// cvl_sequencer: microprogram step counter
// Fetches one control word per step from the ROM, evaluates its jump
// condition against the datapath flags and stalls on a busy result register.
// ----------------------------------------------------------------------------
module cvl_sequencer
  import cvl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ucode_t ctrl,
  output logic   idle
);

  step_t  step_r;
  step_t  step_nxt;
  ucode_t word;
  logic   hold;
  logic   take;

  assign word = ucode_rom(step_r);
  assign idle = (step_r == STEP_FETCH);

  // Freeze a result step while the previous result is still waiting
  assign hold = word.emit && flags.out_busy;
  assign ctrl = hold ? UCODE_NOP : word;

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      COND_NEXT:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !flags.in_fire;
      COND_DELETE:   take = flags.is_delete;
      COND_FULL:     take = flags.full;
      COND_EMPTY:    take = flags.empty;
      COND_END:      take = flags.at_end;
      COND_MISMATCH: take = !flags.match;
      default:       take = 1'b0;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  // An accepted item always finds the sequencer at the fetch step
  a_fire_at_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    flags.in_fire |-> step_r == STEP_FETCH)
    else $error("input transfer outside the fetch step");

  // A stalled result step does not move
  a_hold_stays: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> $stable(step_r))
    else $error("sequencer moved while its result was blocked");

  // Leaving the fetch step means an item was taken
  a_leave_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_FETCH && !flags.in_fire |=> step_r == STEP_FETCH)
    else $error("sequencer left fetch without an item");

endmodule

// File: src/cvl_datapath.sv
// ----------------------------------------------------------------------------
// cvl_datapath: list store, count, index and result register
// Carries out the operations of one control word: index update, store write,
// count update and result load. Reads the store at the index every cycle.
// ----------------------------------------------------------------------------
module cvl_datapath
  import cvl_pkg::*;
#(
  parameter int CAPACITY = 128
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  ucode_t    ctrl,
  input  logic      in_fire,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output flags_t    flags,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [31:0] mem [CAPACITY];

  logic               cmd_r;
  logic signed [31:0] value_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      idx_nxt;
  logic [CW-1:0]      idx_dec;
  logic signed [31:0] rd_data_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic [CW+7:0]      count_ext;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_data.command;
      value_r <= in_data.value;
    end
  end

  // Index and count updates
  always_comb begin
    case (ctrl.idx_op)
      IDX_ZERO: idx_nxt = '0;
      IDX_INC:  idx_nxt = idx_r + CW'(1);
      default:  idx_nxt = idx_r;
    endcase
    case (ctrl.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Store write: append at the end, or move an entry down one place
  assign idx_dec = idx_r - CW'(1);
  always_comb begin
    case (ctrl.wr_op)
      WR_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count_r[AW-1:0];
        wr_data = value_r;
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_dec[AW-1:0];
        wr_data = rd_data_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = count_r[AW-1:0];
        wr_data = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read at the current index
  always_ff @(posedge clk) begin
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  // Result register: load on a result step, drop after the transfer
  assign count_ext = {8'd0, count_nxt};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_data_r.status <= ctrl.status;
      out_data_r.count  <= count_ext[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Flags for the sequencer
  assign flags.in_fire   = in_fire;
  assign flags.is_delete = (cmd_r == CMD_DELETE);
  assign flags.full      = (count_r == CW'(CAPACITY));
  assign flags.empty     = (count_r == '0);
  assign flags.at_end    = (idx_r == count_r);
  assign flags.match     = (rd_data_r == value_r);
  assign flags.out_busy  = out_valid_r && out_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_op == WR_APPEND |-> count_r < CW'(CAPACITY))
    else $error("append into a full store");

  a_shift_index: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_op == WR_SHIFT |-> idx_r != '0 && idx_r < count_r)
    else $error("shift write outside the list");

endmodule

// File: sim/tb_compacting_value_list.sv
// ----------------------------------------------------------------------------
// tb_compacting_value_list: self-checking bench for the compacting value list
// Sends append and delete commands through the valid/stall input channel and
// checks each result against a behavioral list model held in a scoreboard.
// A short directed run covers the corner cases. A random run follows that
// fills the list to capacity and drains it again, with sender and receiver
// idling in two different mixes and then running without idling.
// ----------------------------------------------------------------------------
module tb_compacting_value_list;
  import cvl_pkg::*;

  localparam int CAPACITY       = 128;
  localparam int ITEMS_PER_MIX  = 135;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 300;

  // Behavioral list model plus the queue of results still owed by the block
  class list_scoreboard;
    int                 capacity;
    logic signed [31:0] entries[$];
    out_item_t          owed_q[$];
    int                 mismatches;

    function new(int capacity_i);
      capacity   = capacity_i;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted command to the model and queue its result
    function void note_command(in_item_t item);
      out_item_t res;
      int        hit;
      res.status = ST_DONE;
      hit        = -1;
      if (item.command == CMD_APPEND) begin
        if (entries.size() >= capacity) res.status = ST_FULL;
        else entries.push_back(item.value);
      end else if (entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // only the first match goes; later entries close the gap
        foreach (entries[i])
          if (hit < 0 && entries[i] == item.value) hit = i;
        if (hit < 0) res.status = ST_NOT_FOUND;
        else entries.delete(hit);
      end
      res.count = 8'(entries.size());
      owed_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest owed result
    task check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d count %0d",
                                  got.status, got.count));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  list_scoreboard sb;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             quiet_cycles;
  bit             growing;

  compacting_value_list #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check result transfers, drive the receiver stall, count quiet cycles
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // End the run if nothing moves for too long
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one command, idling first at random, and hold it until transferred
  task automatic send_item(in_item_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_command(item);
  endtask

  task automatic send_cmd(logic cmd, logic signed [31:0] value);
    in_item_t item;
    item.command = cmd;
    item.value   = value;
    send_item(item);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Grow the list to capacity, then shrink it to empty, over and over;
  // half the values are taken from the held entries, so deletes often hit and appends repeat
  function automatic in_item_t pick_item();
    in_item_t item;
    int       n;
    n = sb.entries.size();
    if (growing && n >= CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
    else if (!growing && n == 0 && $urandom_range(3) == 0) growing = 1'b1;
    item.command = ($urandom_range(99) < (growing ? 85 : 15)) ? CMD_APPEND : CMD_DELETE;
    case ($urandom_range(3))
      0:       item.value = $urandom;
      1:       item.value = 32'($urandom_range(8)) - 32'sd4;
      default: item.value = (n > 0) ? sb.entries[$urandom_range(n - 1)] : $urandom;
    endcase
    return item;
  endfunction

  initial begin
    sb            = new(CAPACITY);
    growing       = 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extreme values, duplicates, misses, compaction
    send_cmd(CMD_DELETE, 32'sd0);
    send_cmd(CMD_APPEND, 32'sh8000_0000);
    send_cmd(CMD_APPEND, 32'sh7fff_ffff);
    send_cmd(CMD_APPEND, 32'sd0);
    send_cmd(CMD_APPEND, -32'sd1);
    send_cmd(CMD_APPEND, 32'sd5);
    send_cmd(CMD_APPEND, 32'sd5);
    send_cmd(CMD_APPEND, -32'sd1);
    send_cmd(CMD_DELETE, 32'sd12345);
    send_cmd(CMD_DELETE, 32'sd5);
    send_cmd(CMD_DELETE, -32'sd1);
    send_cmd(CMD_DELETE, 32'sh8000_0000);
    send_cmd(CMD_DELETE, 32'sd5);
    send_cmd(CMD_DELETE, -32'sd1);
    send_cmd(CMD_DELETE, 32'sh7fff_ffff);
    send_cmd(CMD_DELETE, 32'sd0);
    send_cmd(CMD_DELETE, 32'sd0);
    send_cmd(CMD_APPEND, 32'shaaaa_aaaa);
    send_cmd(CMD_APPEND, 32'sh5555_5555);
    send_cmd(CMD_DELETE, 32'sh5555_5555);
    send_cmd(CMD_DELETE, 32'shaaaa_aaab);
    send_cmd(CMD_DELETE, 32'shaaaa_aaaa);
    drain();

    // Random: two idling mixes and one without idling, with an occasional full drain
    for (int mix = 0; mix < 3; mix++) begin
      send_idle_pct = (mix == 0) ? 9 : (mix == 1) ? 79 : 0;
      recv_idle_pct = (mix == 0) ? 79 : (mix == 1) ? 9 : 0;
      for (int k = 0; k < ITEMS_PER_MIX; k++) begin
        send_item(pick_item());
        if ($urandom_range(39) == 0) drain();
      end
      drain();
    end

    // Settle: catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
